// File: src/plcf_pkg.sv
package plcf_pkg;

  localparam int PosW     = 32;
  localparam int CompW    = 21;
  localparam int CfgIdxW  = 32;
  localparam int CfgDataW = 64;
  localparam int PackW    = 63;
  localparam int FricW    = 17;

  localparam logic [PackW-1:0] NormalReset = PackW'(1) << 61;

  typedef enum logic [2:0] {
    REG_NORMAL   = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_LINEAR   = 3'd2,
    REG_ANGULAR  = 3'd3,
    REG_PIVOT    = 3'd4,
    REG_FRICTION = 3'd5
  } cfg_reg_t;

  typedef struct {
    logic signed [CompW-1:0] n   [3];
    logic signed [PosW-1:0]  offset;
    logic signed [CompW-1:0] lin [3];
    logic signed [CompW-1:0] ang [3];
    logic signed [CompW-1:0] piv [3];
    logic        [FricW-1:0] friction;
  } cfg_t;

  // push stage result toward the collider motion stages
  typedef struct {
    logic                   valid;
    logic                   hit;
    logic signed [PosW-1:0] p  [3];
    logic signed [PosW-1:0] q  [3];
    logic signed [PosW-1:0] np [3];
    logic signed [33:0]     r  [3];
  } push_t;

  // relative displacement toward the friction stages
  typedef struct {
    logic                   valid;
    logic                   hit;
    logic signed [PosW-1:0] p   [3];
    logic signed [PosW-1:0] q   [3];
    logic signed [PosW-1:0] np  [3];
    logic signed [37:0]     rel [3];
  } motion_t;

  function automatic logic signed [PosW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return hi[PosW-1:0];
    if (v < lo) return lo[PosW-1:0];
    return v[PosW-1:0];
  endfunction

  function automatic logic signed [CompW-1:0] field21(input logic [PackW-1:0] w,
                                                       input int k);
    return $signed(w[CompW*k +: CompW]);
  endfunction

endpackage

// File: src/plcf_cfg.sv
module plcf_cfg
  import plcf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  logic [CfgIdxW-1:0]  index,
  input  logic [CfgDataW-1:0] data,
  output cfg_t                cfg
);

  logic [PackW-1:0]       normal;
  logic signed [PosW-1:0] offset;
  logic [PackW-1:0]       linear;
  logic [PackW-1:0]       angular;
  logic [PackW-1:0]       pivot;
  logic [FricW-1:0]       friction;

  // register file, out of range indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      normal   <= NormalReset;
      offset   <= '0;
      linear   <= '0;
      angular  <= '0;
      pivot    <= '0;
      friction <= '0;
    end else if (wr && (index < CfgIdxW'(6))) begin
      unique case (cfg_reg_t'(index[2:0]))
        REG_NORMAL:   normal   <= data[PackW-1:0];
        REG_OFFSET:   offset   <= $signed(data[PosW-1:0]);
        REG_LINEAR:   linear   <= data[PackW-1:0];
        REG_ANGULAR:  angular  <= data[PackW-1:0];
        REG_PIVOT:    pivot    <= data[PackW-1:0];
        REG_FRICTION: friction <= data[FricW-1:0];
        default: ;
      endcase
    end
  end

  // unpack the component vectors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg.n[i]   = field21(normal, i);
      cfg.lin[i] = field21(linear, i);
      cfg.ang[i] = field21(angular, i);
      cfg.piv[i] = field21(pivot, i);
    end
    cfg.offset   = offset;
    cfg.friction = friction;
  end

endmodule

// File: src/plcf_push.sv
module plcf_push
  import plcf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_ok,
  input  logic signed [PosW-1:0] p_in [3],
  input  logic signed [PosW-1:0] q_in [3],
  input  cfg_t                   cfg,
  output push_t                  res
);

  logic v1, v2, v3;
  logic signed [PosW-1:0] p1 [3], q1 [3], p2 [3], q2 [3], p3 [3], q3 [3];
  logic signed [52:0] pn1 [3];
  logic hit2, hit3;
  logic signed [36:0] pen2;
  logic signed [57:0] push3 [3];

  logic signed [63:0] dot, offs, diff, pen_w, sh, npw;
  logic signed [PosW-1:0] np_c [3];
  logic signed [33:0] r_c [3];

  // contact test and penetration depth
  always_comb begin
    dot   = 64'(pn1[0]) + 64'(pn1[1]) + 64'(pn1[2]);
    offs  = 64'(cfg.offset) <<< 19;
    diff  = offs - dot;
    pen_w = (diff + 64'sd262144) >>> 19;
  end

  // pushed position and lever arm about the pivot
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh      = (64'(push3[i]) + 64'sd262144) >>> 19;
      np_c[i] = sat32(64'(p3[i]) + sh);
      npw     = 64'(np_c[i]) - (64'(cfg.piv[i]) <<< 6);
      r_c[i]  = npw[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      res.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_ok;
      v2 <= v1;
      v3 <= v2;
      res.valid <= v3;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1[i]  <= p_in[i];
        q1[i]  <= q_in[i];
        pn1[i] <= p_in[i] * cfg.n[i];
        p2[i]  <= p1[i];
        q2[i]  <= q1[i];
        p3[i]  <= p2[i];
        q3[i]  <= q2[i];
        push3[i] <= cfg.n[i] * pen2;
        res.p[i]  <= p3[i];
        res.q[i]  <= q3[i];
        res.np[i] <= np_c[i];
        res.r[i]  <= r_c[i];
      end
      hit2 <= (dot <= offs);
      pen2 <= pen_w[36:0];
      hit3 <= hit2;
      res.hit <= hit3;
    end
  end

endmodule

// File: src/plcf_motion.sv
module plcf_motion
  import plcf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  push_t   din,
  input  cfg_t    cfg,
  output motion_t res
);

  logic v5, hit5;
  logic signed [PosW-1:0] p5 [3], q5 [3], np5 [3];
  logic signed [54:0] ma5 [3], mb5 [3];

  logic signed [63:0] c, cd, relw;
  logic signed [63:0] cd_hi, cd_lo;
  logic signed [37:0] rel_c [3];

  // collider displacement and relative motion
  always_comb begin
    cd_hi = 64'sd34359738367;
    cd_lo = -64'sd34359738368;
    for (int i = 0; i < 3; i++) begin
      c  = (64'(ma5[i]) - 64'(mb5[i]) + 64'sd512) >>> 10;
      cd = (64'(cfg.lin[i]) <<< 6) + c;
      if (cd > cd_hi) cd = cd_hi;
      else if (cd < cd_lo) cd = cd_lo;
      relw = 64'(np5[i]) - 64'(q5[i]) - cd;
      rel_c[i] = relw[37:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      res.valid <= 1'b0;
    end else if (en) begin
      v5 <= din.valid;
      res.valid <= v5;
    end
    if (en) begin
      hit5 <= din.hit;
      res.hit <= hit5;
      for (int i = 0; i < 3; i++) begin
        p5[i]  <= din.p[i];
        q5[i]  <= din.q[i];
        np5[i] <= din.np[i];
        ma5[i] <= cfg.ang[(i + 1) % 3] * din.r[(i + 2) % 3];
        mb5[i] <= cfg.ang[(i + 2) % 3] * din.r[(i + 1) % 3];
        res.p[i]   <= p5[i];
        res.q[i]   <= q5[i];
        res.np[i]  <= np5[i];
        res.rel[i] <= rel_c[i];
      end
    end
  end

endmodule

// File: src/plcf_damp.sv
module plcf_damp
  import plcf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  motion_t                din,
  input  cfg_t                   cfg,
  output logic                   valid,
  output logic                   hit,
  output logic signed [PosW-1:0] np_out [3],
  output logic signed [PosW-1:0] nq_out [3]
);

  logic v7, v8, v9, v10, v11;
  logic h7, h8, h9, h10, h11;
  logic signed [PosW-1:0] p7 [3], p8 [3], p9 [3], p10 [3], p11 [3];
  logic signed [PosW-1:0] q7 [3], q8 [3], q9 [3], q10 [3], q11 [3];
  logic signed [PosW-1:0] n7 [3], n8 [3], n9 [3], n10 [3], n11 [3];
  logic signed [37:0] rel7 [3], rel8 [3], rel9 [3];
  logic signed [58:0] rn7 [3];
  logic signed [41:0] mag8;
  logic signed [62:0] nm9 [3];
  logic signed [43:0] nv10 [3], nv11 [3];
  logic signed [44:0] tv10 [3];
  logic signed [62:0] tf11 [3];

  logic signed [63:0] msum, magw, nvw, tvw, vel;
  logic signed [41:0] mag_c;
  logic signed [43:0] nv_c [3];
  logic signed [44:0] tv_c [3];
  logic signed [PosW-1:0] nq_c [3];
  logic signed [17:0] factor;

  // normal magnitude of the relative motion
  always_comb begin
    msum  = 64'(rn7[0]) + 64'(rn7[1]) + 64'(rn7[2]);
    magw  = (msum + 64'sd262144) >>> 19;
    mag_c = magw[41:0];
  end

  // normal and tangential split
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nvw     = (64'(nm9[i]) + 64'sd262144) >>> 19;
      nv_c[i] = nvw[43:0];
      tvw     = 64'(rel9[i]) - nvw;
      tv_c[i] = tvw[44:0];
    end
  end

  // damped velocity and rebuilt previous position
  always_comb begin
    factor = 18'sd65536 - $signed({1'b0, cfg.friction});
    for (int i = 0; i < 3; i++) begin
      vel     = 64'(nv11[i]) + ((64'(tf11[i]) + 64'sd32768) >>> 16);
      nq_c[i] = sat32(64'(n11[i]) - vel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v7 <= din.valid;
      v8 <= v7;
      v9 <= v8;
      v10 <= v9;
      v11 <= v10;
      valid <= v11;
    end
    if (en) begin
      h7 <= din.hit;
      h8 <= h7;
      h9 <= h8;
      h10 <= h9;
      h11 <= h10;
      hit <= h11;
      mag8 <= mag_c;
      for (int i = 0; i < 3; i++) begin
        p7[i] <= din.p[i];
        q7[i] <= din.q[i];
        n7[i] <= din.np[i];
        rel7[i] <= din.rel[i];
        rn7[i] <= din.rel[i] * cfg.n[i];
        p8[i] <= p7[i];
        q8[i] <= q7[i];
        n8[i] <= n7[i];
        rel8[i] <= rel7[i];
        p9[i] <= p8[i];
        q9[i] <= q8[i];
        n9[i] <= n8[i];
        rel9[i] <= rel8[i];
        nm9[i] <= cfg.n[i] * mag8;
        p10[i] <= p9[i];
        q10[i] <= q9[i];
        n10[i] <= n9[i];
        nv10[i] <= nv_c[i];
        tv10[i] <= tv_c[i];
        p11[i] <= p10[i];
        q11[i] <= q10[i];
        n11[i] <= n10[i];
        nv11[i] <= nv10[i];
        tf11[i] <= tv10[i] * factor;
        np_out[i] <= h11 ? n11[i] : p11[i];
        nq_out[i] <= h11 ? nq_c[i] : q11[i];
      end
    end
  end

endmodule

// File: src/plane_collision_friction_resolve.sv
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   pos_x..z, prev_x..z
// out      output     out_valid/out_stall new_pos_x..z, new_prev_x..z, contact
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// twelve register stages, one particle a cycle unless out_stall holds the pipe;
// the stages follow the chain of multiplies, each followed by a register
// synchronous active-high reset empties the pipe and loads register defaults
// out_stall with a valid result freezes every stage; in_stall follows it

module plane_collision_friction_resolve
  import plcf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [PosW-1:0] pos_x,
  input  logic signed [PosW-1:0] pos_y,
  input  logic signed [PosW-1:0] pos_z,
  input  logic signed [PosW-1:0] prev_x,
  input  logic signed [PosW-1:0] prev_y,
  input  logic signed [PosW-1:0] prev_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PosW-1:0] new_pos_x,
  output logic signed [PosW-1:0] new_pos_y,
  output logic signed [PosW-1:0] new_pos_z,
  output logic signed [PosW-1:0] new_prev_x,
  output logic signed [PosW-1:0] new_prev_y,
  output logic signed [PosW-1:0] new_prev_z,
  output logic                   contact,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0]    cfg_data
);

  cfg_t    cfg;
  push_t   ps;
  motion_t mo;
  logic    en;
  logic signed [PosW-1:0] p_in [3], q_in [3], np [3], nq [3];

  // pipe advances unless a finished request is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  assign p_in[0] = pos_x;
  assign p_in[1] = pos_y;
  assign p_in[2] = pos_z;
  assign q_in[0] = prev_x;
  assign q_in[1] = prev_y;
  assign q_in[2] = prev_z;

  plcf_cfg u_cfg (
    .clk(clk), .rst(rst), .wr(cfg_valid), .index(cfg_index), .data(cfg_data), .cfg(cfg)
  );

  plcf_push u_push (
    .clk(clk), .rst(rst), .en(en), .in_ok(in_valid), .p_in(p_in), .q_in(q_in),
    .cfg(cfg), .res(ps)
  );

  plcf_motion u_motion (
    .clk(clk), .rst(rst), .en(en), .din(ps), .cfg(cfg), .res(mo)
  );

  plcf_damp u_damp (
    .clk(clk), .rst(rst), .en(en), .din(mo), .cfg(cfg), .valid(out_valid),
    .hit(contact), .np_out(np), .nq_out(nq)
  );

  assign new_pos_x  = np[0];
  assign new_pos_y  = np[1];
  assign new_pos_z  = np[2];
  assign new_prev_x = nq[0];
  assign new_prev_y = nq[1];
  assign new_prev_z = nq[2];

`ifndef SYNTHESIS
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ps.valid) && $stable(mo.valid) && out_valid)
    else $error("pipeline valid moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !ps.valid && !mo.valid)
    else $error("pipeline not empty after reset");

  a_stall_path: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");
`endif

endmodule

// File: verif/plane_collision_friction_resolve_test.sv
`timescale 1ns / 1ps

module plane_collision_friction_resolve_test;
  import plcf_pkg::*;

  typedef struct {
    logic signed [31:0] p [3];
    logic signed [31:0] q [3];
  } particle_t;

  typedef struct {
    logic signed [31:0] np [3];
    logic signed [31:0] nq [3];
    logic               hit;
  } resolved_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] prev_x = '0, prev_y = '0, prev_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
  logic signed [31:0] new_prev_x, new_prev_y, new_prev_z;
  logic contact;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  plane_collision_friction_resolve dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // collider and plane settings mirrored from the register writes
  logic [62:0] normal_r, linear_r, angular_r, pivot_r;
  logic signed [63:0] offset_r, friction_r;

  particle_t pending_particles[$];
  resolved_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit stall_hold = 1'b0;
  bit pause_send = 1'b0;
  int burst_left = 0, gap_left = 0;
  int stall_left = 0, stall_mode = 0;

  function automatic logic signed [63:0] comp21(logic [62:0] w, int k);
    return 64'(signed'(w[21*k +: 21]));
  endfunction

  // floor shift after adding half: rounds half toward plus infinity
  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] x, int k);
    return (x + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [63:0] clip(logic signed [63:0] v,
                                               logic signed [63:0] lo,
                                               logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic resolved_t resolve_particle(particle_t pt);
    resolved_t res;
    logic signed [63:0] n [3], w [3], r [3], rel [3], nv [3], npw [3];
    logic signed [63:0] dot, pen, mag, factor, c, cd, tv, lim;
    int a, b;
    dot = 0;
    lim = 64'sd34359738368;
    for (int i = 0; i < 3; i++) begin
      n[i] = comp21(normal_r, i);
      dot += 64'(pt.p[i]) * n[i];
    end
    res.hit = dot <= offset_r * 524288;
    if (!res.hit) begin
      res.np = pt.p;
      res.nq = pt.q;
      return res;
    end
    pen = rnd_shift(offset_r * 524288 - dot, 19);
    for (int i = 0; i < 3; i++) begin
      npw[i] = clip(64'(pt.p[i]) + rnd_shift(n[i] * pen, 19),
                    -64'sd2147483648, 64'sd2147483647);
      res.np[i] = npw[i][31:0];
      w[i] = comp21(angular_r, i);
      r[i] = npw[i] - comp21(pivot_r, i) * 64;
    end
    mag = 0;
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      b = (i + 2) % 3;
      c = rnd_shift(w[a] * r[b] - w[b] * r[a], 10);
      cd = clip(comp21(linear_r, i) * 64 + c, -lim, lim - 1);
      rel[i] = (npw[i] - 64'(pt.q[i])) - cd;
      mag += rel[i] * n[i];
    end
    mag = rnd_shift(mag, 19);
    factor = 65536 - friction_r;
    for (int i = 0; i < 3; i++) begin
      nv[i] = rnd_shift(n[i] * mag, 19);
      tv = rel[i] - nv[i];
      res.nq[i] = 32'(clip(npw[i] - (nv[i] + rnd_shift(tv * factor, 16)),
                           -64'sd2147483648, 64'sd2147483647));
    end
    return res;
  endfunction

  // request driver: bursts and gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst && !(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_results.push_back(resolve_particle(pending_particles.pop_front()));
      end
      if (gap_left > 0) gap_left <= gap_left - 1;
      if (pending_particles.size() > 0 && !pause_send && gap_left == 0) begin
        in_valid <= 1'b1;
        {pos_x, pos_y, pos_z} <= {pending_particles[0].p[0], pending_particles[0].p[1],
                                  pending_particles[0].p[2]};
        {prev_x, prev_y, prev_z} <= {pending_particles[0].q[0], pending_particles[0].q[1],
                                     pending_particles[0].q[2]};
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and stall pattern
  always @(posedge clk) begin
    resolved_t exp_r;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (new_pos_x !== exp_r.np[0]) begin
          $error("new_pos_x exp %0d got %0d", exp_r.np[0], new_pos_x); errors++;
        end
        if (new_pos_y !== exp_r.np[1]) begin
          $error("new_pos_y exp %0d got %0d", exp_r.np[1], new_pos_y); errors++;
        end
        if (new_pos_z !== exp_r.np[2]) begin
          $error("new_pos_z exp %0d got %0d", exp_r.np[2], new_pos_z); errors++;
        end
        if (new_prev_x !== exp_r.nq[0]) begin
          $error("new_prev_x exp %0d got %0d", exp_r.nq[0], new_prev_x); errors++;
        end
        if (new_prev_y !== exp_r.nq[1]) begin
          $error("new_prev_y exp %0d got %0d", exp_r.nq[1], new_prev_y); errors++;
        end
        if (new_prev_z !== exp_r.nq[2]) begin
          $error("new_prev_z exp %0d got %0d", exp_r.nq[2], new_prev_z); errors++;
        end
        if (contact !== exp_r.hit) begin
          $error("contact exp %0d got %0d", exp_r.hit, contact); errors++;
        end
      end
    end
    if (stall_hold) out_stall <= 1'b1;
    else if (stall_left > 0) stall_left <= stall_left - 1;
    else begin
      stall_left <= $urandom_range(0, 40);
      stall_mode <= $urandom_range(0, 3);
    end
    if (!stall_hold) begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("plane_collision_friction_resolve: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CfgIdxW'(idx);
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NORMAL: normal_r = value[62:0];
      REG_OFFSET: offset_r = 64'(signed'(value[31:0]));
      REG_LINEAR: linear_r = value[62:0];
      REG_ANGULAR: angular_r = value[62:0];
      REG_PIVOT: pivot_r = value[62:0];
      REG_FRICTION: friction_r = 64'(value[16:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_particles.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [20:0] rnd21();
    case ($urandom_range(0, 4))
      0: return 21'h100000;
      1: return 21'h0fffff;
      2: return 21'($urandom_range(0, 2047)) - 21'd1024;
      default: return 21'($urandom);
    endcase
  endfunction

  function automatic logic [62:0] rnd_pack();
    return {rnd21(), rnd21(), rnd21()};
  endfunction

  function automatic logic [62:0] unitish_normal();
    logic [20:0] c [3];
    int ax;
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) c[i] = 21'($urandom_range(0, 200000)) - 21'd100000;
    c[ax] = $urandom_range(0, 1) ? 21'h080000 : 21'h180000;
    return {c[2], c[1], c[0]};
  endfunction

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $urandom;
      default: return 32'($urandom_range(0, 2 * 655360)) - 32'sd655360;
    endcase
  endfunction

  task automatic add_particle(logic signed [31:0] a, b, c, d, e, f);
    particle_t pt;
    pt.p = '{a, b, c};
    pt.q = '{d, e, f};
    pending_particles.push_back(pt);
  endtask

  task automatic add_random(int count);
    logic signed [31:0] px, py, pz;
    for (int k = 0; k < count; k++) begin
      px = rnd_coord(); py = rnd_coord(); pz = rnd_coord();
      if ($urandom_range(0, 1))
        add_particle(px, py, pz, px + 32'($urandom_range(0, 8192)) - 4096,
                     py + 32'($urandom_range(0, 8192)) - 4096,
                     pz + 32'($urandom_range(0, 8192)) - 4096);
      else add_particle(px, py, pz, rnd_coord(), rnd_coord(), rnd_coord());
    end
  endtask

  initial begin
    normal_r = NormalReset;
    offset_r = 0;
    linear_r = '0;
    angular_r = '0;
    pivot_r = '0;
    friction_r = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, touching plane, extremes
    add_particle(0, 0, 0, 0, 0, 0);
    add_particle(0, 0, -65536, 100, 200, 300);
    add_particle(0, 0, 65536, 0, 0, 0);
    add_particle(32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    add_particle(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    add_particle(-1, -1, -1, -1, -1, -1);
    drain();

    write_reg(REG_NORMAL, 64'h7fff_ffff_ffff_ffff);
    write_reg(REG_OFFSET, 64'h7fffffff);
    write_reg(REG_LINEAR, {1'b1, 63'h7fff_ffff_ffff_ffff});
    write_reg(REG_ANGULAR, {21'h100000, 21'h0fffff, 21'h100000});
    write_reg(REG_PIVOT, {21'h0fffff, 21'h100000, 21'h0fffff});
    write_reg(REG_FRICTION, 64'h1ffff);
    write_reg(cfg_reg_t'(3'd7), 64'hdead);
    add_particle(0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
    add_particle(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    add_particle(12345, -6789, 65536, -1, 1, 0);
    drain();

    write_reg(REG_OFFSET, 64'hffff_ffff_8000_0000);
    write_reg(REG_FRICTION, 64'd65536);
    add_particle(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
    add_particle(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    drain();
    write_reg(REG_FRICTION, 64'd0);

    // random phases with new settings each time
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_NORMAL, $urandom_range(0, 3) == 0 ? rnd_pack() : unitish_normal());
      write_reg(REG_OFFSET, $urandom_range(0, 3) == 0 ? 64'($urandom)
                : 64'($signed(32'($urandom_range(0, 262144)) - 32'sd131072)));
      write_reg(REG_LINEAR, rnd_pack());
      write_reg(REG_ANGULAR, rnd_pack());
      write_reg(REG_PIVOT, rnd_pack());
      case ($urandom_range(0, 3))
        0: write_reg(REG_FRICTION, 64'd0);
        1: write_reg(REG_FRICTION, 64'd65536);
        2: write_reg(REG_FRICTION, 64'($urandom_range(65537, 131071)));
        default: write_reg(REG_FRICTION, 64'($urandom_range(0, 65536)));
      endcase
      add_random(200);
      if (ph == 3) begin
        // long receiver hold-off so the pipe fills and backs up
        stall_hold = 1'b1;
        repeat (200) @(posedge clk);
        stall_hold = 1'b0;
      end
      if (ph == 6) begin
        // sender pauses until everything has come back
        wait (pending_particles.size() < 100);
        pause_send = 1'b1;
        wait (!in_valid && expected_results.size() == 0);
        pause_send = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("plane_collision_friction_resolve: match");
    else $display("plane_collision_friction_resolve: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
src/plcf_pkg.sv
src/plcf_cfg.sv
src/plcf_push.sv
src/plcf_motion.sv
src/plcf_damp.sv
src/plane_collision_friction_resolve.sv
verif/plane_collision_friction_resolve_test.sv
